// ----- hw/rtl/rolling_hash_substring_search_top_macros.svh -----
// assertion macros used by the checker file
`ifndef ROLLING_HASH_SUBSTRING_SEARCH_TOP_MACROS_SVH
`define ROLLING_HASH_SUBSTRING_SEARCH_TOP_MACROS_SVH

// same-cycle implication on the rising clock edge
`define RHSS_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("rhss assertion failed");

// next-cycle implication on the rising clock edge
`define RHSS_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("rhss assertion failed");

`endif

// ----- hw/rtl/rhss_pkg.sv -----
`default_nettype none

package rhss_pkg;

   localparam int MAX_PATTERN_DEF   = 64;
   localparam int POSITION_BITS_DEF = 16;

   typedef enum logic [1:0] {
      ACT_START   = 2'd0,
      ACT_PATTERN = 2'd1,
      ACT_TEXT    = 2'd2
   } action_type;

   typedef struct packed {
      logic check;
      logic clear;
      logic overflow;
   } step_flags_type;

   // x * 37 modulo 2^64
   function automatic logic [63:0] mul37(input logic [63:0] x);
      mul37 = (x << 5) + (x << 2) + x;
   endfunction

   // x * sign-extended byte, modulo 2^64
   function automatic logic [63:0] mul_sbyte(input logic [63:0] x, input logic [7:0] b);
      logic [63:0] prod;
      prod = x * {56'd0, b};
      mul_sbyte = b[7] ? (prod - (x << 8)) : prod;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rolling_hash_substring_search_top.sv -----
// rolling-hash substring search, one result transaction per request transaction
// req channel: req_action (0 start, 1 pattern byte, 2 text byte), req_symbol
// rsp channel: rsp_match, rsp_position, rsp_found_any, rsp_pattern_overflow
// a start clears all search state; pattern bytes build the pattern hash,
// text bytes roll the window hash and report a match at the window start
// a result passes the input register, the hash update into the mid register and
// the compare into the result register before rsp_valid rises
// throughput: one transaction per cycle while rsp_ready is high; the window hash
// update and the ring buffer read/write for one text byte fit in the update stage
// the text ring is a MAX_PATTERN-byte memory with a registered read port
// that is prefetched at the next head, so it never stalls the pipeline
// when rsp_ready is low the result register holds and the stages behind it
// fill up; req_ready drops once all three stages are occupied
// synchronous reset empties the pipeline and restores the start state

`default_nettype none

module rolling_hash_substring_search_top
   import rhss_pkg::*;
#(
   parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire logic [1:0]               req_action,
   input  wire logic [7:0]               req_symbol,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic                     rsp_match,
   output      logic [POSITION_BITS-1:0] rsp_position,
   output      logic                     rsp_found_any,
   output      logic                     rsp_pattern_overflow
);

   logic                     a_valid_ff;
   logic [1:0]               a_action_ff;
   logic [7:0]               a_symbol_ff;
   logic                     mid_valid_ff;
   step_flags_type           mid_flags_ff;
   logic [POSITION_BITS-1:0] mid_pos_ff;
   logic                     out_valid_ff;
   logic                     out_match_ff;
   logic [POSITION_BITS-1:0] out_pos_ff;
   logic                     out_found_ff;
   logic                     out_ovf_ff;

   logic                     a_move;
   logic                     mid_move;
   step_flags_type           step_flags;
   logic [POSITION_BITS-1:0] step_pos;
   logic                     hit;
   logic                     match_in;
   logic                     found_in;

   assign mid_move  = mid_valid_ff && (!out_valid_ff || rsp_ready);
   assign a_move    = a_valid_ff && (!mid_valid_ff || mid_move);
   assign req_ready = !a_valid_ff || a_move;

   rhss_engine #(
      .MAX_PATTERN   (MAX_PATTERN),
      .POSITION_BITS (POSITION_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (a_move),
      .action (a_action_ff),
      .symbol (a_symbol_ff),
      .flags  (step_flags),
      .pos    (step_pos),
      .hit    (hit)
   );

   // compare sees the hash state left by the transaction in the mid stage
   assign match_in = mid_flags_ff.check && hit;
   assign found_in = (mid_flags_ff.clear ? 1'b0 : out_found_ff) | match_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         out_found_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            a_valid_ff <= req_valid;
         end
         if (!mid_valid_ff || mid_move) begin
            mid_valid_ff <= a_move;
         end
         if (!out_valid_ff || rsp_ready) begin
            out_valid_ff <= mid_move;
         end
         if (mid_move) begin
            out_found_ff <= found_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_action_ff <= req_action;
         a_symbol_ff <= req_symbol;
      end
      if (a_move) begin
         mid_flags_ff <= step_flags;
         mid_pos_ff   <= step_pos;
      end
      if (mid_move) begin
         out_match_ff <= match_in;
         out_pos_ff   <= match_in ? mid_pos_ff : '0;
         out_ovf_ff   <= mid_flags_ff.overflow;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_match            = out_match_ff;
   assign rsp_position         = out_pos_ff;
   assign rsp_found_any        = out_found_ff;
   assign rsp_pattern_overflow = out_ovf_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rhss_engine.sv -----
`default_nettype none

module rhss_engine
   import rhss_pkg::*;
#(
   parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic [1:0]               action,
   input  wire logic [7:0]               symbol,
   output      step_flags_type           flags,
   output      logic [POSITION_BITS-1:0] pos,
   output      logic                     hit
);

   localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
   localparam int RING_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [63:0]              target_ff, target_in;
   logic [63:0]              pat_power_ff, pat_power_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [POSITION_BITS-1:0] count_ff, count_in;
   logic [63:0]              window_ff, window_in;
   logic [63:0]              pow_cur_ff, pow_cur_in;
   logic [63:0]              pow_start_ff, pow_start_in;
   logic                     ovf_ff, ovf_in;
   logic [RING_AW-1:0]       head_ff, head_in;
   logic                     full_ff, full_in;
   logic                     started_ff, started_in;

   logic [7:0]               ring [MAX_PATTERN];
   logic [7:0]               ring_rd_ff;
   logic                     ring_we;
   logic [LEN_W-1:0]         head_inc;
   logic [63:0]              window_tmp;
   logic [POSITION_BITS+LEN_W-1:0] pos_wide;

   always_comb begin
      target_in    = target_ff;
      pat_power_in = pat_power_ff;
      len_in       = len_ff;
      count_in     = count_ff;
      window_in    = window_ff;
      pow_cur_in   = pow_cur_ff;
      pow_start_in = pow_start_ff;
      ovf_in       = ovf_ff;
      head_in      = head_ff;
      full_in      = full_ff;
      started_in   = started_ff;
      ring_we      = 1'b0;
      head_inc     = LEN_W'(head_ff) + LEN_W'(1);
      window_tmp   = window_ff;
      flags.check  = 1'b0;
      flags.clear  = 1'b0;
      if (step) begin
         unique case (action)
            ACT_START: begin
               target_in    = '0;
               pat_power_in = 64'd1;
               len_in       = '0;
               count_in     = '0;
               window_in    = '0;
               pow_cur_in   = 64'd1;
               pow_start_in = 64'd1;
               ovf_in       = 1'b0;
               head_in      = '0;
               full_in      = 1'b0;
               started_in   = 1'b0;
               flags.clear  = 1'b1;
            end
            ACT_PATTERN: begin
               if (!started_ff) begin
                  if (len_ff < LEN_W'(MAX_PATTERN)) begin
                     target_in    = target_ff + mul_sbyte(pat_power_ff, symbol);
                     pat_power_in = mul37(pat_power_ff);
                     len_in       = len_ff + LEN_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
            ACT_TEXT: begin
               started_in = 1'b1;
               count_in   = count_ff + POSITION_BITS'(1);
               if (len_ff != '0) begin
                  if (full_ff) begin
                     window_tmp   = window_ff - mul_sbyte(pow_start_ff, ring_rd_ff);
                     pow_start_in = mul37(pow_start_ff);
                     target_in    = mul37(target_ff);
                  end
                  window_in  = window_tmp + mul_sbyte(pow_cur_ff, symbol);
                  pow_cur_in = mul37(pow_cur_ff);
                  ring_we    = 1'b1;
                  if (head_inc == len_ff) begin
                     head_in = '0;
                     full_in = 1'b1;
                  end else begin
                     head_in = RING_AW'(head_inc);
                  end
                  flags.check = full_in;
               end
            end
            default: ;
         endcase
      end
      flags.overflow = ovf_in;
   end

   assign pos_wide = {{LEN_W{1'b0}}, count_in} - {{POSITION_BITS{1'b0}}, len_ff}
                     + (POSITION_BITS + LEN_W)'(1);
   assign pos      = pos_wide[POSITION_BITS-1:0];
   assign hit      = (window_ff == target_ff);

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[head_ff] <= symbol;
      end
      if (ring_we && (head_ff == head_in)) begin
         ring_rd_ff <= symbol;
      end else begin
         ring_rd_ff <= ring[head_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         pat_power_ff <= 64'd1;
         len_ff       <= '0;
         count_ff     <= '0;
         window_ff    <= '0;
         pow_cur_ff   <= 64'd1;
         pow_start_ff <= 64'd1;
         ovf_ff       <= 1'b0;
         head_ff      <= '0;
         full_ff      <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         target_ff    <= target_in;
         pat_power_ff <= pat_power_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         window_ff    <= window_in;
         pow_cur_ff   <= pow_cur_in;
         pow_start_ff <= pow_start_in;
         ovf_ff       <= ovf_in;
         head_ff      <= head_in;
         full_ff      <= full_in;
         started_ff   <= started_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/rhss_checker.sv -----
`default_nettype none

`include "rolling_hash_substring_search_top_macros.svh"

module rhss_checker #(
   parameter int POSITION_BITS = 16
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic                     rsp_match,
   input wire logic [POSITION_BITS-1:0] rsp_position,
   input wire logic                     rsp_found_any,
   input wire logic                     rsp_pattern_overflow
);

   // no match means no position
   `RHSS_ASSERT_IMPLY(a_pos_zero, clock, reset, rsp_valid && !rsp_match, rsp_position == '0)

   // a match is always reflected in the sticky flag
   `RHSS_ASSERT_IMPLY(a_found_sticky, clock, reset, rsp_valid && rsp_match, rsp_found_any)

   // pipeline empties on reset
   `RHSS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // with the result register empty the request side never stalls
   `RHSS_ASSERT_IMPLY(a_ready_when_empty, clock, reset, req_valid && !rsp_valid, req_ready)

   // stalled result holds
   `RHSS_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_position) && $stable(rsp_pattern_overflow))

endmodule

bind rolling_hash_substring_search_top rhss_checker #(
   .POSITION_BITS (POSITION_BITS)
) u_rhss_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import rhss_pkg::*;

   localparam int MAX_PAT = MAX_PATTERN_DEF;
   localparam int POS_W = POSITION_BITS_DEF;
   localparam logic [63:0] HASH_BASE = 64'd37;
   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam int RANDOM_ITEMS = 480;
   localparam int TAIL_TEXT_LEN = 60;

   typedef struct packed {
      logic match;
      logic [POS_W-1:0] position;
      logic found_any;
      logic pattern_overflow;
   } search_result_type;

   class match_scoreboard;
      search_result_type expected_results[$];
      int errors = 0;

      logic [63:0] pat_hash;
      logic [63:0] pat_power;
      int pat_len;
      logic [7:0] text_ring [MAX_PAT];
      logic [POS_W-1:0] text_count;
      logic [63:0] window_sum;
      logic [63:0] power_current;
      logic [63:0] power_start;
      logic found;
      logic overflow;
      int ring_head;
      bit ring_full;
      bit text_started;

      function new();
         clear_search();
      endfunction

      function void clear_search();
         pat_hash = '0;
         pat_power = 64'd1;
         pat_len = 0;
         foreach (text_ring[i]) text_ring[i] = '0;
         text_count = '0;
         window_sum = '0;
         power_current = 64'd1;
         power_start = 64'd1;
         found = 1'b0;
         overflow = 1'b0;
         ring_head = 0;
         ring_full = 1'b0;
         text_started = 1'b0;
      endfunction

      function logic [63:0] sext(logic [7:0] b);
         return {{56{b[7]}}, b};
      endfunction

      function void note_request(logic [1:0] action, logic [7:0] symbol);
         logic [63:0] c;
         search_result_type r;
         int h;
         int start_pos;
         c = sext(symbol);
         r = '0;
         case (action)
            ACT_START: begin
               clear_search();
            end
            ACT_PATTERN: begin
               if (!text_started) begin
                  if (pat_len < MAX_PAT) begin
                     pat_hash = pat_hash + c * pat_power;
                     pat_power = pat_power * HASH_BASE;
                     pat_len++;
                  end else begin
                     overflow = 1'b1;
                  end
               end
            end
            ACT_TEXT: begin
               text_started = 1'b1;
               text_count = text_count + 1'b1;
               if (pat_len > 0) begin
                  h = ring_head;
                  if (h >= pat_len) h = 0;
                  if (ring_full) begin
                     window_sum = window_sum - sext(text_ring[h]) * power_start;
                     power_start = power_start * HASH_BASE;
                  end
                  window_sum = window_sum + c * power_current;
                  power_current = power_current * HASH_BASE;
                  text_ring[h] = symbol;
                  h++;
                  if (h >= pat_len) begin
                     h = 0;
                     ring_full = 1'b1;
                  end
                  ring_head = h;
                  if (ring_full && window_sum == pat_hash * power_start) begin
                     found = 1'b1;
                     start_pos = int'(text_count) - pat_len + 1;
                     r.match = 1'b1;
                     r.position = start_pos[POS_W-1:0];
                  end
               end
            end
            default: ;
         endcase
         r.found_any = found;
         r.pattern_overflow = overflow;
         expected_results.push_back(r);
      endfunction

      function void check_response(search_result_type got);
         search_result_type exp_r;
         if (expected_results.size() == 0) begin
            $error("response with no transaction outstanding");
            errors++;
            return;
         end
         exp_r = expected_results.pop_front();
         if (got.match !== exp_r.match) begin
            $error("rsp_match expected %0d actual %0d", exp_r.match, got.match);
            errors++;
         end
         if (got.position !== exp_r.position) begin
            $error("rsp_position expected %0d actual %0d", exp_r.position, got.position);
            errors++;
         end
         if (got.found_any !== exp_r.found_any) begin
            $error("rsp_found_any expected %0d actual %0d", exp_r.found_any, got.found_any);
            errors++;
         end
         if (got.pattern_overflow !== exp_r.pattern_overflow) begin
            $error("rsp_pattern_overflow expected %0d actual %0d",
                   exp_r.pattern_overflow, got.pattern_overflow);
            errors++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_action = ACT_START;
   logic [7:0] req_symbol = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_match;
   logic [POS_W-1:0] rsp_position;
   logic rsp_found_any;
   logic rsp_pattern_overflow;

   match_scoreboard sb = new();
   bit idle_on = 1'b1;
   int rsp_hold_len = 0;
   int items_sent = 0;

   rolling_hash_substring_search_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_symbol(req_symbol),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_match(rsp_match),
      .rsp_position(rsp_position),
      .rsp_found_any(rsp_found_any),
      .rsp_pattern_overflow(rsp_pattern_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_top failed");
      $finish;
   end

   // response side: checks and backpressure
   initial begin
      int stall_left;
      search_result_type got;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.match = rsp_match;
            got.position = rsp_position;
            got.found_any = rsp_found_any;
            got.pattern_overflow = rsp_pattern_overflow;
            sb.check_response(got);
         end
         if (rsp_hold_len > 0) begin
            stall_left = rsp_hold_len;
            rsp_hold_len = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 11);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send(input logic [1:0] action, input logic [7:0] symbol);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_symbol <= symbol;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(action, symbol);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // one search: start, pattern, then text with copies of the pattern mixed in
   task automatic run_search(input int pat_len, input int text_len, input bit noisy);
      logic [7:0] pat[$];
      logic [7:0] sym_a;
      logic [7:0] sym_b;
      logic [7:0] s;
      int emb;
      sym_a = 8'($urandom);
      sym_b = 8'($urandom);
      emb = -1;
      send(ACT_START, 8'($urandom));
      for (int i = 0; i < pat_len; i++) begin
         if ($urandom_range(0, 4) == 0) s = 8'($urandom);
         else s = $urandom_range(0, 1) ? sym_a : sym_b;
         pat.push_back(s);
         send(ACT_PATTERN, s);
      end
      for (int i = 0; i < text_len; i++) begin
         if (noisy && $urandom_range(0, 19) == 0) send(2'($urandom_range(0, 3)), 8'($urandom));
         if (emb < 0 && pat.size() > 0 && $urandom_range(0, 5) == 0) emb = 0;
         if (emb >= 0) begin
            s = pat[emb];
            emb++;
            if (emb >= pat.size() || emb >= MAX_PAT) emb = -1;
         end else begin
            s = $urandom_range(0, 1) ? sym_a : sym_b;
         end
         send(ACT_TEXT, s);
      end
   endtask

   initial begin
      int pat_len;
      int text_len;
      int pick;
      int wait_cnt;
      logic [7:0] sym_a;
      logic [7:0] sym_b;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty pattern, pattern after text
      send(ACT_START, 8'h00);
      send(ACT_TEXT, 8'hFF);
      send(ACT_PATTERN, 8'h55);
      send(ACT_TEXT, 8'h55);
      // sign extremes in pattern and text
      send(ACT_START, 8'hFF);
      send(ACT_PATTERN, 8'h00);
      send(ACT_PATTERN, 8'hFF);
      send(ACT_PATTERN, 8'h80);
      send(ACT_PATTERN, 8'h7F);
      send(ACT_TEXT, 8'h7F);
      send(ACT_TEXT, 8'h00);
      send(ACT_TEXT, 8'hFF);
      send(ACT_TEXT, 8'h80);
      send(ACT_TEXT, 8'h7F);
      send(ACT_PATTERN, 8'h7F);
      send(ACT_NONE, 8'hAA);
      send(ACT_TEXT, 8'h00);
      send(ACT_TEXT, 8'hFF);
      send(ACT_TEXT, 8'h80);
      drain();

      // long receiver hold while requests keep coming
      rsp_hold_len = 200;
      run_search(4, 40, 1'b0);
      drain();

      while (items_sent < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 9);
         if (pick == 0) pat_len = $urandom_range(60, 70);
         else if (pick == 1) pat_len = 0;
         else pat_len = $urandom_range(1, 6);
         if (pat_len > 6) text_len = $urandom_range(pat_len, pat_len + 30);
         else text_len = $urandom_range(0, 25);
         run_search(pat_len, text_len, $urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0) drain();
      end

      // tail run with no idling
      idle_on = 1'b0;
      sym_a = 8'($urandom);
      sym_b = ~sym_a;
      send(ACT_START, 8'($urandom));
      send(ACT_PATTERN, sym_a);
      send(ACT_PATTERN, sym_b);
      for (int i = 0; i < TAIL_TEXT_LEN; i++) begin
         send(ACT_TEXT, $urandom_range(0, 1) ? sym_a : sym_b);
      end

      req_valid <= 1'b0;
      wait_cnt = 0;
      while (sb.pending() != 0 && wait_cnt < 5000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d responses never arrived", sb.pending());
      end
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
